// File: src/hamming_message_encoder_core_assert.svh
// Assertion macros for the Hamming message encoder.
// Self-contained: used by hamming_message_encoder_core.sv, needs nothing else.
`ifndef HAMMING_MESSAGE_ENCODER_CORE_ASSERT_SVH
`define HAMMING_MESSAGE_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication under reset.
`define HME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hme assertion failed");
// Next-cycle implication under reset.
`define HME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hme assertion failed");
`else
`define HME_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/hme_pkg.sv
// Beat types and fixed constants of the Hamming message encoder.
// No dependencies; imported by hamming_message_encoder_core.
`default_nettype none

package hme_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int CHUNK_BITS = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] code_chunk;
    logic [3:0] chunk_bits;
    logic       last_chunk;
    logic       overflow;
  } out_beat_t;

endpackage

`default_nettype wire

// File: src/hamming_message_encoder_core.sv
// Hamming message encoder top level: byte store, bit-serial scan and emit.
// Depends on hme_pkg and hamming_message_encoder_core_assert.svh.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid / in_stall | in_beat_t: data_byte, final_byte
//   out_    | output    | out_valid/out_stall | out_beat_t: chunk, bits, last, ovf
//
// A byte that is not final gives no beat.
// A final byte starts encoding: an r search, a parity scan over all n codeword
// positions (one bit a cycle), then an emit pass (one bit a cycle while the
// output slot is free); the one-bit shift path through the codeword positions
// sets the pace of both passes.
// in_stall is high from the final byte until the last chunk is in the output
// register; out_stall freezes the emit pass only while a beat waits.
// Reset (rst_n low, synchronous) empties the message and the output register.
`default_nettype none

module hamming_message_encoder_core
  import hme_pkg::*;
#(
  parameter int MAX_BYTES = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire in_beat_t in_beat,
  output logic       out_valid,
  input  wire        out_stall,
  output out_beat_t  out_beat
);

  localparam int KMAX = MAX_BYTES * BYTE_BITS;
  localparam int NMAX = KMAX + 16;
  localparam int PW   = $clog2(NMAX + 1);
  localparam int CW   = $clog2(MAX_BYTES + 1);
  localparam int IW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int RW   = $clog2(PW + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Message bytes; only entries below the byte count feed the codeword.
  logic [7:0] msg_mem [MAX_BYTES];

  state_t         state_r,     state_nxt;
  logic [CW-1:0]  byte_cnt_r,  byte_cnt_nxt;
  logic           ovf_r,       ovf_nxt;
  logic [RW-1:0]  r_r,         r_nxt;
  logic [PW:0]    pow_r,       pow_nxt;
  logic [PW-1:0]  n_r,         n_nxt;
  logic [PW-1:0]  pos_r,       pos_nxt;
  logic [PW-1:0]  acc_r,       acc_nxt;
  logic [7:0]     sh_r,        sh_nxt;
  logic [2:0]     bit_idx_r,   bit_idx_nxt;
  logic [IW-1:0]  rd_idx_r,    rd_idx_nxt;
  logic [7:0]     chunk_r,     chunk_nxt;
  logic [3:0]     chunk_cnt_r, chunk_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_beat_t      out_beat_r,  out_beat_nxt;

  logic           in_acc;
  logic           store_ok;
  logic [PW-1:0]  k_bits;
  logic [PW:0]    limit;
  logic [PW-1:0]  pos_dec;
  logic           is_pow2;
  logic           slot_free;
  logic           code_bit;
  logic           consume;
  logic           chunk_done;
  logic [7:0]     chunk_ins;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign store_ok  = (byte_cnt_r < CW'(MAX_BYTES));
  assign k_bits    = PW'(byte_cnt_r) << 3;
  assign limit     = (PW + 1)'(k_bits) + (PW + 1)'(r_r) + (PW + 1)'(1);
  assign pos_dec   = pos_r - PW'(1);
  assign is_pow2   = ((pos_r & pos_dec) == '0);
  assign slot_free = !out_valid_r || !out_stall;

  // Parity positions carry their accumulated bit, the rest carry message bits.
  assign code_bit   = is_pow2 ? |(acc_r & pos_r) : sh_r[7];
  assign chunk_ins  = chunk_r | (8'(code_bit) << (3'd7 - chunk_cnt_r[2:0]));
  assign chunk_done = (chunk_cnt_r == 4'(CHUNK_BITS - 1)) || (pos_r == PW'(1));

  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    ovf_nxt       = ovf_r;
    r_nxt         = r_r;
    pow_nxt       = pow_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    bit_idx_nxt   = bit_idx_r;
    rd_idx_nxt    = rd_idx_r;
    chunk_nxt     = chunk_r;
    chunk_cnt_nxt = chunk_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    consume       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (store_ok) begin
            byte_cnt_nxt = byte_cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_beat.final_byte) begin
            r_nxt     = '0;
            pow_nxt   = (PW + 1)'(1);
            state_nxt = ST_CALC;
          end
        end
      end

      ST_CALC: begin
        // Grow r until 2^r covers k + r + 1 positions.
        if (pow_r < limit) begin
          pow_nxt = pow_r << 1;
          r_nxt   = r_r + RW'(1);
        end else begin
          n_nxt       = k_bits + PW'(r_r);
          pos_nxt     = k_bits + PW'(r_r);
          acc_nxt     = '0;
          sh_nxt      = msg_mem[0];
          bit_idx_nxt = '0;
          rd_idx_nxt  = IW'(1);
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!is_pow2) begin
          consume = 1'b1;
          if (sh_r[7]) begin
            acc_nxt = acc_r ^ pos_r;
          end
        end
        pos_nxt = pos_dec;
        if (pos_r == PW'(1)) begin
          // Rewind to the top position for the emit pass.
          pos_nxt       = n_r;
          sh_nxt        = msg_mem[0];
          bit_idx_nxt   = '0;
          rd_idx_nxt    = IW'(1);
          chunk_nxt     = '0;
          chunk_cnt_nxt = '0;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          consume = !is_pow2;
          pos_nxt = pos_dec;
          if (chunk_done) begin
            out_valid_nxt           = 1'b1;
            out_beat_nxt.code_chunk = chunk_ins;
            out_beat_nxt.chunk_bits = chunk_cnt_r + 4'd1;
            out_beat_nxt.last_chunk = (pos_r == PW'(1));
            out_beat_nxt.overflow   = ovf_r;
            chunk_nxt               = '0;
            chunk_cnt_nxt           = '0;
          end else begin
            chunk_nxt     = chunk_ins;
            chunk_cnt_nxt = chunk_cnt_r + 4'd1;
          end
          if (pos_r == PW'(1)) begin
            byte_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            acc_nxt      = '0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance the message bit stream; reload the shifter at each byte end.
    if (consume && (state_nxt == state_r)) begin
      if (bit_idx_r == 3'd7) begin
        sh_nxt      = msg_mem[rd_idx_r];
        rd_idx_nxt  = rd_idx_r + IW'(1);
        bit_idx_nxt = '0;
      end else begin
        sh_nxt      = sh_r << 1;
        bit_idx_nxt = bit_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byte_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      ovf_r       <= ovf_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r         <= r_nxt;
    pow_r       <= pow_nxt;
    n_r         <= n_nxt;
    sh_r        <= sh_nxt;
    bit_idx_r   <= bit_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chunk_r     <= chunk_nxt;
    chunk_cnt_r <= chunk_cnt_nxt;
    out_beat_r  <= out_beat_nxt;
  end

  // Store each accepted byte while there is room; drop it otherwise.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      msg_mem[byte_cnt_r[IW-1:0]] <= in_beat.data_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`include "hamming_message_encoder_core_assert.svh"

  `HME_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, byte_cnt_r <= CW'(MAX_BYTES))
  `HME_ASSERT_NOW(a_pos_range, clk, rst_n,
                  (state_r == ST_SCAN) || (state_r == ST_EMIT),
                  (pos_r != '0) && (pos_r <= n_r))
  `HME_ASSERT_NOW(a_bits_range, clk, rst_n, out_valid_r,
                  (out_beat_r.chunk_bits != 4'd0) && (out_beat_r.chunk_bits <= 4'd8))
  `HME_ASSERT_NOW(a_full_chunk, clk, rst_n, out_valid_r && !out_beat_r.last_chunk,
                  out_beat_r.chunk_bits == 4'd8)
  `HME_ASSERT_NEXT(a_emit_end, clk, rst_n,
                   (state_r == ST_EMIT) && slot_free && (pos_r == PW'(1)),
                   (state_r == ST_IDLE) && (byte_cnt_r == '0) && out_valid_r
                   && out_beat_r.last_chunk)

endmodule

`default_nettype wire
